>>> hdl/hswd_pkg.sv
// Shared types and constants for the height step wall detector.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package hswd_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int ALT_BITS_DEF  = 16;

  localparam int THR_BITS      = 15;
  localparam int GW_BITS       = 11;
  localparam int GH_BITS       = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 2;

  localparam int COL_OUT_BITS  = 10;
  localparam int ROW_BITS      = 16;

  localparam int MIN_DIM       = 3;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [THR_BITS-1:0] THR_RESET = 15'd50;
  localparam logic [GW_BITS-1:0]  GW_RESET  = 11'd1024;
  localparam logic [GH_BITS-1:0]  GH_RESET  = 16'd1024;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_STEP_THRESHOLD = 2'd0,
    REG_GRID_WIDTH     = 2'd1,
    REG_GRID_HEIGHT    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [THR_BITS-1:0] step_threshold;
    logic [GW_BITS-1:0]  grid_width;
    logic [GH_BITS-1:0]  grid_height;
  } hswd_cfg_t;

  // One flag per result a pixel can release: cell above, cell to the left, final cell.
  typedef struct packed {
    logic up;
    logic left;
    logic fin;
  } hswd_set_t;

  typedef struct packed {
    logic [COL_OUT_BITS-1:0] col;
    logic [ROW_BITS-1:0]     row;
    hswd_set_t               emit;
    hswd_set_t               blk;
  } hswd_cls_t;

  typedef enum logic [1:0] {
    SEL_UP    = 2'd0,
    SEL_LEFT  = 2'd1,
    SEL_FINAL = 2'd2
  } hswd_sel_t;

endpackage

>>> hdl/hswd_if.sv
// Stream interfaces for altitude samples in and classified cells out.
// Depends on hswd_pkg for widths.
interface hswd_alt_if #(
  parameter int ALT_BITS = hswd_pkg::ALT_BITS_DEF
) ();
  logic                       valid;
  logic                       ready;
  logic signed [ALT_BITS-1:0] altitude;

  modport source (output valid, output altitude, input ready);
  modport sink   (input valid, input altitude, output ready);
endinterface

interface hswd_res_if ();
  logic                              valid;
  logic                              ready;
  logic                              blocked;
  logic [hswd_pkg::COL_OUT_BITS-1:0] cell_column;
  logic [hswd_pkg::ROW_BITS-1:0]     cell_row;
  logic                              frame_end;

  modport source (output valid, output blocked, output cell_column, output cell_row,
                  output frame_end, input ready);
  modport sink   (input valid, input blocked, input cell_column, input cell_row,
                  input frame_end, output ready);
endinterface

>>> hdl/hswd_front.sv
// Front end: raster counters, the two line stores and the step classification.
// Pushes one entry per pixel that releases results. Depends on hswd_pkg, hswd_if.
module hswd_front #(
  parameter int MAX_WIDTH = hswd_pkg::MAX_WIDTH_DEF,
  parameter int ALT_BITS  = hswd_pkg::ALT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  hswd_pkg::hswd_cfg_t cfg,
  hswd_alt_if.sink            pixels,
  output logic                q_valid,
  input  logic                q_ready,
  output hswd_pkg::hswd_cls_t q_entry
);

  localparam int ADDR_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_BITS  = hswd_pkg::ROW_BITS;
  localparam int WIDE_BITS = 32;
  localparam int THR_WIDE  = hswd_pkg::THR_BITS + 1;
  localparam int LOW_BITS  = ((ALT_BITS > THR_WIDE) ? ALT_BITS : THR_WIDE) + 1;

  logic [ADDR_BITS-1:0] col_cnt;
  logic [ROW_BITS-1:0]  row_cnt;

  logic signed [ALT_BITS-1:0] above_mem [MAX_WIDTH];
  logic signed [ALT_BITS-1:0] two_mem   [MAX_WIDTH];

  logic                       s1_valid;
  logic [ADDR_BITS-1:0]       s1_col;
  logic [ROW_BITS-1:0]        s1_row;
  logic                       s1_last_col;
  logic                       s1_last_row;
  logic signed [ALT_BITS-1:0] s1_alt;
  logic signed [ALT_BITS-1:0] s1_above;
  logic signed [ALT_BITS-1:0] s1_right;
  logic signed [ALT_BITS-1:0] s1_two;

  logic signed [ALT_BITS-1:0] left_sample;
  logic signed [ALT_BITS-1:0] last_alt;
  logic signed [ALT_BITS-1:0] last_alt2;

  logic                 pix_acc;
  logic                 s1_take;
  logic                 any_emit;
  logic [WIDE_BITS-1:0] w_eff;
  logic [WIDE_BITS-1:0] h_eff;
  logic                 last_col;
  logic                 last_row;
  logic [ADDR_BITS-1:0] right_addr;

  logic signed [LOW_BITS-1:0] thr_ext;
  logic signed [LOW_BITS-1:0] low_up;
  logic signed [LOW_BITS-1:0] low_left;
  logic signed [LOW_BITS-1:0] low_cur;
  logic                       col_ge1;
  logic                       col_ge2;
  logic                       row_ge1;
  logic                       row_ge2;
  hswd_pkg::hswd_set_t        emit;
  hswd_pkg::hswd_set_t        blk;

  function automatic logic step_hit(input logic signed [LOW_BITS-1:0] low,
                                    input logic signed [ALT_BITS-1:0] nb);
    step_hit = low > LOW_BITS'(nb);
  endfunction

  always_comb begin
    if (WIDE_BITS'(cfg.grid_width) < WIDE_BITS'(hswd_pkg::MIN_DIM)) begin
      w_eff = WIDE_BITS'(hswd_pkg::MIN_DIM);
    end else if (WIDE_BITS'(cfg.grid_width) > WIDE_BITS'(MAX_WIDTH)) begin
      w_eff = WIDE_BITS'(MAX_WIDTH);
    end else begin
      w_eff = WIDE_BITS'(cfg.grid_width);
    end
    if (WIDE_BITS'(cfg.grid_height) < WIDE_BITS'(hswd_pkg::MIN_DIM)) begin
      h_eff = WIDE_BITS'(hswd_pkg::MIN_DIM);
    end else begin
      h_eff = WIDE_BITS'(cfg.grid_height);
    end
  end

  assign last_col   = (WIDE_BITS'(col_cnt) + WIDE_BITS'(1)) >= w_eff;
  assign last_row   = (WIDE_BITS'(row_cnt) + WIDE_BITS'(1)) >= h_eff;
  assign right_addr = last_col ? col_cnt : col_cnt + ADDR_BITS'(1);

  assign s1_take      = s1_valid && (!any_emit || q_ready);
  assign pixels.ready = !s1_valid || s1_take;
  assign pix_acc      = pixels.valid && pixels.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt  <= '0;
      row_cnt  <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (pix_acc) begin
        s1_valid <= 1'b1;
        if (last_col) begin
          col_cnt <= '0;
          row_cnt <= last_row ? '0 : row_cnt + ROW_BITS'(1);
        end else begin
          col_cnt <= col_cnt + ADDR_BITS'(1);
        end
      end else if (s1_take) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_col      <= col_cnt;
      s1_row      <= row_cnt;
      s1_last_col <= last_col;
      s1_last_row <= last_row;
      s1_alt      <= pixels.altitude;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_above           <= above_mem[col_cnt];
      s1_right           <= above_mem[right_addr];
      above_mem[col_cnt] <= pixels.altitude;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_two <= two_mem[col_cnt];
    end
    if (s1_take) begin
      two_mem[s1_col] <= s1_above;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_sample <= '0;
      last_alt    <= '0;
      last_alt2   <= '0;
    end else if (s1_take) begin
      left_sample <= s1_above;
      last_alt    <= s1_alt;
      last_alt2   <= last_alt;
    end
  end

  always_comb begin
    thr_ext  = LOW_BITS'($signed({1'b0, cfg.step_threshold}));
    low_up   = LOW_BITS'(s1_above) - thr_ext;
    low_left = LOW_BITS'(last_alt) - thr_ext;
    low_cur  = LOW_BITS'(s1_alt) - thr_ext;
    col_ge1  = s1_col != '0;
    col_ge2  = s1_col >= ADDR_BITS'(2);
    row_ge1  = s1_row != '0;
    row_ge2  = s1_row >= ROW_BITS'(2);

    emit.up   = row_ge1;
    emit.left = s1_last_row && col_ge1;
    emit.fin  = s1_last_row && s1_last_col;

    blk.up   = (col_ge1 && step_hit(low_up, left_sample))
            || (!s1_last_col && step_hit(low_up, s1_right))
            || (row_ge2 && step_hit(low_up, s1_two))
            || step_hit(low_up, s1_alt);
    blk.left = (col_ge2 && step_hit(low_left, last_alt2))
            || step_hit(low_left, s1_alt)
            || (row_ge1 && step_hit(low_left, left_sample));
    blk.fin  = (col_ge1 && step_hit(low_cur, last_alt))
            || (row_ge1 && step_hit(low_cur, s1_above));

    any_emit     = emit.up || emit.left || emit.fin;
    q_valid      = s1_valid && any_emit;
    q_entry.col  = hswd_pkg::COL_OUT_BITS'(s1_col);
    q_entry.row  = s1_row;
    q_entry.emit = emit;
    q_entry.blk  = blk;
  end

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    WIDE_BITS'(col_cnt) < WIDE_BITS'(MAX_WIDTH))
    else $error("column counter left the line store");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_take |=> s1_valid && $stable(s1_col) && $stable(s1_alt))
    else $error("classification stage lost a stalled pixel");

endmodule

>>> hdl/hswd_queue.sv
// Short queue of classified entries between front end and result sequencer.
// Depends on hswd_pkg.
module hswd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                push_ready,
  input  hswd_pkg::hswd_cls_t push_data,
  output logic                pop_valid,
  input  logic                pop,
  output hswd_pkg::hswd_cls_t pop_data
);

  localparam int DEPTH    = hswd_pkg::QUEUE_DEPTH;
  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  hswd_pkg::hswd_cls_t  slots [DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr;
  logic [PTR_BITS-1:0]  rd_ptr;
  logic [CNT_BITS-1:0]  count;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = count != CNT_BITS'(DEPTH);
  assign pop_valid  = count != '0;
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_BITS'(1);
        2'b01:   count <= count - CNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(DEPTH))
    else $error("queue fill count beyond depth");

endmodule

>>> hdl/hswd_back.sv
// Back end: expands each queued entry into its one to three results, in order,
// through a registered output stage. Depends on hswd_pkg, hswd_if.
module hswd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_pop,
  input  hswd_pkg::hswd_cls_t q_entry,
  hswd_res_if.source          results
);

  localparam int COL_BITS = hswd_pkg::COL_OUT_BITS;
  localparam int ROW_BITS = hswd_pkg::ROW_BITS;

  hswd_pkg::hswd_cls_t cur;
  hswd_pkg::hswd_set_t pend;
  hswd_pkg::hswd_set_t pend_next;
  hswd_pkg::hswd_sel_t sel;
  logic                any_pend;
  logic                last_one;
  logic                load;

  always_comb begin
    any_pend = pend.up || pend.left || pend.fin;
    last_one = (pend.up ^ pend.left ^ pend.fin) && !(pend.up && pend.left && pend.fin);
    load     = any_pend && (!results.valid || results.ready);
    q_pop    = q_valid && (!any_pend || (load && last_one));

    priority if (pend.up) begin
      sel = hswd_pkg::SEL_UP;
    end else if (pend.left) begin
      sel = hswd_pkg::SEL_LEFT;
    end else begin
      sel = hswd_pkg::SEL_FINAL;
    end

    pend_next = pend;
    if (load) begin
      unique case (sel)
        hswd_pkg::SEL_UP:    pend_next.up   = 1'b0;
        hswd_pkg::SEL_LEFT:  pend_next.left = 1'b0;
        hswd_pkg::SEL_FINAL: pend_next.fin  = 1'b0;
        default:             pend_next      = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (q_pop) begin
      pend <= q_entry.emit;
    end else begin
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unique case (sel)
        hswd_pkg::SEL_UP: begin
          results.blocked     <= cur.blk.up;
          results.cell_column <= cur.col;
          results.cell_row    <= cur.row - ROW_BITS'(1);
          results.frame_end   <= 1'b0;
        end
        hswd_pkg::SEL_LEFT: begin
          results.blocked     <= cur.blk.left;
          results.cell_column <= cur.col - COL_BITS'(1);
          results.cell_row    <= cur.row;
          results.frame_end   <= 1'b0;
        end
        hswd_pkg::SEL_FINAL: begin
          results.blocked     <= cur.blk.fin;
          results.cell_column <= cur.col;
          results.cell_row    <= cur.row;
          results.frame_end   <= 1'b1;
        end
        default: begin
          results.blocked     <= 1'b0;
          results.cell_column <= '0;
          results.cell_row    <= '0;
          results.frame_end   <= 1'b0;
        end
      endcase
    end
  end

  a_entry_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_entry.emit != '0))
    else $error("empty entry reached the result sequencer");

  a_final_drains: assert property (@(posedge clk) disable iff (rst)
    load && sel == hswd_pkg::SEL_FINAL |=> (pend == '0) || $past(q_pop))
    else $error("results left pending after the final cell");

endmodule

>>> hdl/height_step_wall_detector_core.sv
// Height step wall detector: takes one signed altitude per cycle in raster order and
// returns, for every grid cell, whether it stands more than step_threshold above any
// in-grid 4-neighbor, tagged with its column and row. A cell is reported once its lower
// neighbor arrives, so results trail the input by one row; in the last row each pixel
// also releases its left neighbor and the final pixel releases itself with frame_end.
// Rows before the last take one pixel per cycle while results are accepted, via the
// classification, queue, entry and output registers. Last-row pixels after the first give
// two results (the final pixel three) and the output register delivers one result per
// cycle, so there the input stalls once the four-entry queue before the sequencer is full.
// The two line stores hold MAX_WIDTH altitudes each and need no clearing after reset.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata while the block is idle.
// Depends on hswd_pkg, hswd_if, hswd_front, hswd_queue and hswd_back.
module height_step_wall_detector_core #(
  parameter int MAX_WIDTH = hswd_pkg::MAX_WIDTH_DEF,
  parameter int ALT_BITS  = hswd_pkg::ALT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [hswd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [hswd_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  hswd_alt_if.sink                           pixels,
  hswd_res_if.source                         results
);

  hswd_pkg::hswd_cfg_t cfg;
  logic                q_push;
  logic                q_push_ready;
  hswd_pkg::hswd_cls_t q_push_data;
  logic                q_pop_valid;
  logic                q_pop;
  hswd_pkg::hswd_cls_t q_pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_threshold <= hswd_pkg::THR_RESET;
      cfg.grid_width     <= hswd_pkg::GW_RESET;
      cfg.grid_height    <= hswd_pkg::GH_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        hswd_pkg::REG_STEP_THRESHOLD:
          cfg.step_threshold <= cfg_wdata[hswd_pkg::THR_BITS-1:0];
        hswd_pkg::REG_GRID_WIDTH:
          cfg.grid_width <= cfg_wdata[hswd_pkg::GW_BITS-1:0];
        hswd_pkg::REG_GRID_HEIGHT:
          cfg.grid_height <= cfg_wdata[hswd_pkg::GH_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  hswd_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .ALT_BITS  (ALT_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .pixels  (pixels),
    .q_valid (q_push),
    .q_ready (q_push_ready),
    .q_entry (q_push_data)
  );

  hswd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop        (q_pop),
    .pop_data   (q_pop_data)
  );

  hswd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_pop_valid),
    .q_pop   (q_pop),
    .q_entry (q_pop_data),
    .results (results)
  );

endmodule
